// ----- hw/rtl/bfu_pkg.sv -----
`timescale 1ns / 1ps

package bfu_pkg;

	localparam int WORD_W = 32;
	localparam int WIN_W  = 40;

	localparam logic [WORD_W-1:0] ALL32 = 32'hffffffff;
	localparam logic [7:0]        ALL8  = 8'hff;

	typedef enum logic [2:0] {
		ACT_TST  = 3'd0,
		ACT_CHG  = 3'd1,
		ACT_CLR  = 3'd2,
		ACT_SET  = 3'd3,
		ACT_EXTU = 3'd4,
		ACT_EXTS = 3'd5,
		ACT_FFO  = 3'd6,
		ACT_INS  = 3'd7
	} action_t;

	// decoded item: width, masks and shift amounts
	typedef struct packed {
		action_t          act;
		logic             mem;
		logic [31:0]      off_full;
		logic [5:0]       w;
		logic [4:0]       rot;
		logic [31:0]      top_mask;
		logic [31:0]      ins_top;
		logic [WIN_W-1:0] src;
		logic [4:0]       bmask;
	} s1_t;

	// aligned item: field at the top of a word, mask and insert in place
	typedef struct packed {
		action_t          act;
		logic             mem;
		logic [31:0]      off_full;
		logic [5:0]       w;
		logic [WIN_W-1:0] src;
		logic [4:0]       bmask;
		logic [31:0]      ftop;
		logic [31:0]      ins_top;
		logic [WIN_W-1:0] pmask;
		logic [WIN_W-1:0] pins;
	} s2_t;

	// resolved item: updated operand, flags, value or find position
	typedef struct packed {
		logic [WIN_W-1:0] upd;
		logic [4:0]       bmask;
		logic             n;
		logic             z;
		logic [31:0]      value;
		logic             ffo;
		logic [5:0]       pos;
		logic [31:0]      off_full;
	} s3_t;

	typedef struct packed {
		logic [WIN_W-1:0] updated_data;
		logic [4:0]       byte_write_mask;
		logic [31:0]      result_value;
		logic             flag_n;
		logic             flag_z;
	} out_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
		logic [63:0] d;
		d = {v, v} << r;
		return d[63:32];
	endfunction

	function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] r);
		logic [63:0] d;
		d = {v, v} >> r;
		return d[31:0];
	endfunction

	// leading zero count in five halving steps; all zero gives 31
	function automatic logic [4:0] clz32(input logic [31:0] v);
		logic [31:0] x;
		logic [4:0]  n;
		x = v;
		n = '0;
		if (x[31:16] == 16'h0) begin
			n[4] = 1'b1;
			x = x << 16;
		end
		if (x[31:24] == 8'h0) begin
			n[3] = 1'b1;
			x = x << 8;
		end
		if (x[31:28] == 4'h0) begin
			n[2] = 1'b1;
			x = x << 4;
		end
		if (x[31:30] == 2'h0) begin
			n[1] = 1'b1;
			x = x << 2;
		end
		if (x[31] == 1'b0) begin
			n[0] = 1'b1;
		end
		return n;
	endfunction

	// bytes of the window touched up to the byte holding the last field bit
	function automatic logic [4:0] byte_mask(input logic [2:0] last);
		logic [4:0] m;
		case (last)
			3'd0: m = 5'b10000;
			3'd1: m = 5'b11000;
			3'd2: m = 5'b11100;
			3'd3: m = 5'b11110;
			default: m = 5'b11111;
		endcase
		return m;
	endfunction

	// widen a byte mask to one bit per window bit
	function automatic logic [WIN_W-1:0] byte_expand(input logic [4:0] m);
		return {{8{m[4]}}, {8{m[3]}}, {8{m[2]}}, {8{m[1]}}, {8{m[0]}}};
	endfunction

endpackage

// ----- hw/rtl/bfu_decode.sv -----
`timescale 1ns / 1ps

module bfu_decode (
	input  logic                        clk,
	input  logic                        en,
	input  bfu_pkg::action_t            action,
	input  logic                        in_memory,
	input  logic [31:0]                 bit_offset,
	input  logic [5:0]                  field_width,
	input  logic [bfu_pkg::WIN_W-1:0]   source_data,
	input  logic [31:0]                 insert_value,
	output bfu_pkg::s1_t                stage_s1
);
	import bfu_pkg::*;

	s1_t        d;
	logic [5:0] w;
	logic [5:0] end_bit;
	logic       modify;

	// width code zero means a full word
	assign w = (field_width[4:0] == 5'd0) ? 6'd32 : {1'b0, field_width[4:0]};

	// offset of the last field bit inside the window
	assign end_bit = {3'b000, bit_offset[2:0]} + w - 6'd1;

	assign modify = (action == ACT_CHG) || (action == ACT_CLR) ||
	                (action == ACT_SET) || (action == ACT_INS);

	// build masks and shift amounts
	always_comb begin
		d.act      = action;
		d.mem      = in_memory;
		d.off_full = bit_offset;
		d.w        = w;
		d.rot      = in_memory ? {2'b00, bit_offset[2:0]} : bit_offset[4:0];
		d.top_mask = ~(ALL32 >> w);
		d.ins_top  = insert_value << (6'd32 - w);
		d.src      = source_data;
		d.bmask    = (in_memory && modify) ? byte_mask(end_bit[5:3]) : 5'b00000;
	end

	// stage 1 register
	always_ff @(posedge clk) begin
		if (en) begin
			stage_s1 <= d;
		end
	end

endmodule

// ----- hw/rtl/bfu_align.sv -----
`timescale 1ns / 1ps

module bfu_align (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  bfu_pkg::s1_t stage_s1,
	output bfu_pkg::s2_t stage_s2
);
	import bfu_pkg::*;

	s2_t              d;
	logic [WIN_W-1:0] win_shl;

	assign win_shl = stage_s1.src << stage_s1.rot[2:0];

	// rotate the register or shift the window so the field sits on top
	always_comb begin
		d.act      = stage_s1.act;
		d.mem      = stage_s1.mem;
		d.off_full = stage_s1.off_full;
		d.w        = stage_s1.w;
		d.src      = stage_s1.src;
		d.bmask    = stage_s1.bmask;
		d.ins_top  = stage_s1.ins_top;
		if (stage_s1.mem) begin
			d.ftop  = win_shl[WIN_W-1:8] & stage_s1.top_mask;
			d.pmask = {stage_s1.top_mask, 8'h00} >> stage_s1.rot[2:0];
			d.pins  = {stage_s1.ins_top, 8'h00} >> stage_s1.rot[2:0];
		end else begin
			d.ftop  = rotl32(stage_s1.src[31:0], stage_s1.rot) & stage_s1.top_mask;
			d.pmask = {8'h00, rotr32(stage_s1.top_mask, stage_s1.rot)};
			d.pins  = {8'h00, rotr32(stage_s1.ins_top, stage_s1.rot)};
		end
	end

	// stage 2 register
	always_ff @(posedge clk) begin
		if (en) begin
			stage_s2 <= d;
		end
	end

	a_mask_bits: assert property (@(posedge clk) disable iff (!arst_n)
		en |-> ($countones(d.pmask) == 32'(stage_s1.w)))
		else $error("placed mask does not hold width bits");

	a_mask_in_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(en && stage_s1.bmask != 5'b00000) |->
		((d.pmask & ~byte_expand(stage_s1.bmask)) == '0))
		else $error("placed mask reaches outside the written bytes");

endmodule

// ----- hw/rtl/bfu_finish.sv -----
`timescale 1ns / 1ps

module bfu_finish (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en_s3,
	input  logic         en_s4,
	input  bfu_pkg::s2_t stage_s2,
	output bfu_pkg::out_t stage_s4
);
	import bfu_pkg::*;

	s3_t              d3;
	s3_t              stage_s3;
	out_t             d4;
	logic [WIN_W-1:0] base;
	logic [5:0]       sr;
	logic [31:0]      flag_src;
	logic [4:0]       lead;

	assign base     = stage_s2.mem ? stage_s2.src : {8'h00, stage_s2.src[31:0]};
	assign sr       = 6'd32 - stage_s2.w;
	assign flag_src = (stage_s2.act == ACT_INS) ? stage_s2.ins_top : stage_s2.ftop;
	assign lead     = clz32(stage_s2.ftop);

	// apply the operation, take flags, right-align the field
	always_comb begin
		d3.bmask    = stage_s2.bmask;
		d3.n        = flag_src[31];
		d3.z        = (flag_src == 32'h0);
		d3.ffo      = (stage_s2.act == ACT_FFO);
		d3.pos      = (stage_s2.ftop == 32'h0) ? stage_s2.w : {1'b0, lead};
		d3.off_full = stage_s2.off_full;
		case (stage_s2.act)
			ACT_CHG: d3.upd = base ^ stage_s2.pmask;
			ACT_CLR: d3.upd = base & ~stage_s2.pmask;
			ACT_SET: d3.upd = base | stage_s2.pmask;
			ACT_INS: d3.upd = (base & ~stage_s2.pmask) | stage_s2.pins;
			default: d3.upd = base;
		endcase
		case (stage_s2.act)
			ACT_EXTU: d3.value = stage_s2.ftop >> sr;
			ACT_EXTS: d3.value = $unsigned($signed(stage_s2.ftop) >>> sr);
			default:  d3.value = 32'h0;
		endcase
	end

	// stage 3 register
	always_ff @(posedge clk) begin
		if (en_s3) begin
			stage_s3 <= d3;
		end
	end

	// add the offset for a find, form the output beat
	always_comb begin
		d4.updated_data    = stage_s3.upd;
		d4.byte_write_mask = stage_s3.bmask;
		d4.result_value    = stage_s3.ffo ? (stage_s3.off_full + {26'h0, stage_s3.pos})
		                                  : stage_s3.value;
		d4.flag_n          = stage_s3.n;
		d4.flag_z          = stage_s3.z;
	end

	// output register
	always_ff @(posedge clk) begin
		if (en_s4) begin
			stage_s4 <= d4;
		end
	end

	a_ffo_in_field: assert property (@(posedge clk) disable iff (!arst_n)
		(en_s3 && stage_s2.ftop != 32'h0) |-> ({1'b0, lead} < stage_s2.w))
		else $error("first one found outside the field");

endmodule

// ----- hw/rtl/bitfield_instruction_unit.sv -----
`timescale 1ns / 1ps

// channel | dir | handshake         | payload
// s_      | in  | s_tvalid/s_tready | s_tdata: action, bit_offset, field_width,
//         |     |                   |   source_data, insert_value; s_tuser: in_memory
// m_      | out | m_tvalid/m_tready | m_tdata: updated_data, byte_write_mask,
//         |     |                   |   result_value, flag_n, flag_z
//
// Four register stages (decode, align, resolve, output); a taken beat passes each in turn
// to reach m_, and one beat is taken every cycle while no stall backs up into s_tready.
// Each stage moves when it is empty or the next one moves, so a stall on m_
// holds the output beat, lets the stages behind it close their gaps, then backs
// up into s_tready.
// arst_n clears the stage valid bits only; the stage data registers are not reset.

module bitfield_instruction_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [2:0] action, [34:3] bit_offset, [40:35] field_width,
	// [80:41] source_data, [112:81] insert_value, [119:113] zero
	input  logic [119:0] s_tdata,
	// [0] in_memory
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [39:0] updated_data, [44:40] byte_write_mask, [76:45] result_value,
	// [77] flag_n, [78] flag_z, [79] zero
	output logic [79:0]  m_tdata
);
	import bfu_pkg::*;

	logic  valid_s1, valid_s2, valid_s3, valid_s4;
	logic  rdy1, rdy2, rdy3, rdy4;
	logic  load_s1, load_s2, load_s3, load_s4;
	s1_t   stage_s1;
	s2_t   stage_s2;
	out_t  stage_s4;

	// a stage takes a beat when it is empty or its beat moves on
	assign rdy4 = !valid_s4 || m_tready;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign load_s1 = rdy1 && s_tvalid;
	assign load_s2 = rdy2 && valid_s1;
	assign load_s3 = rdy3 && valid_s2;
	assign load_s4 = rdy4 && valid_s3;

	assign s_tready = rdy1;
	assign m_tvalid = valid_s4;

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	bfu_decode u_decode (
		.clk          (clk),
		.en           (load_s1),
		.action       (action_t'(s_tdata[2:0])),
		.in_memory    (s_tuser),
		.bit_offset   (s_tdata[34:3]),
		.field_width  (s_tdata[40:35]),
		.source_data  (s_tdata[80:41]),
		.insert_value (s_tdata[112:81]),
		.stage_s1     (stage_s1)
	);

	bfu_align u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (load_s2),
		.stage_s1 (stage_s1),
		.stage_s2 (stage_s2)
	);

	bfu_finish u_finish (
		.clk      (clk),
		.arst_n   (arst_n),
		.en_s3    (load_s3),
		.en_s4    (load_s4),
		.stage_s2 (stage_s2),
		.stage_s4 (stage_s4)
	);

	// pack the output beat
	assign m_tdata = {1'b0, stage_s4.flag_z, stage_s4.flag_n, stage_s4.result_value,
	                  stage_s4.byte_write_mask, stage_s4.updated_data};

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && valid_s4 && !m_tready) |-> !s_tready)
		else $error("input taken while every stage is held");

endmodule

// ----- test/bitfield_instruction_unit_test.sv -----
`timescale 1ns / 1ps

module bitfield_instruction_unit_test;

	import bfu_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PIPE_DRAIN  = 8;

	// one bit-field instruction as it enters the unit
	typedef struct {
		action_t          act;
		logic             mem;
		logic [31:0]      offset;
		logic [5:0]       width;
		logic [WIN_W-1:0] src;
		logic [31:0]      ins;
	} bf_op_t;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [119:0] s_tdata  = '0;
	logic         s_tuser  = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [79:0]  m_tdata;

	out_t expected_q[$];
	bit   idle_en    = 1'b1;
	int   mismatches = 0;
	int   cycles     = 0;

	bitfield_instruction_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// end the run as failed once the cycle limit is reached
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// stall the result side at random while idling is enabled
	always @(negedge clk) begin
		m_tready <= !idle_en || ($urandom_range(99) >= 36);
	end

	function automatic logic [31:0] spin_left(input logic [31:0] v, input int unsigned r);
		// shifting by 32 yields zero, so r == 0 needs no special case
		return (v << r) | (v >> (32 - r));
	endfunction

	function automatic logic [31:0] spin_right(input logic [31:0] v, input int unsigned r);
		return (v >> r) | (v << (32 - r));
	endfunction

	// compute the result beat that one instruction must produce
	function automatic out_t predict_bitfield(input bf_op_t op);
		out_t             res;
		int unsigned      w;
		int unsigned      off;
		int unsigned      sh;
		int unsigned      last;
		int unsigned      pos;
		logic [31:0]      wmask;
		logic [31:0]      fld;
		logic [31:0]      ins_fld;
		logic [31:0]      reg_val;
		logic [31:0]      m32;
		logic [WIN_W-1:0] m40;
		logic [WIN_W-1:0] upd;
		logic [4:0]       bmask;
		logic             n;

		// only the low five width bits count, zero meaning 32
		w = (op.width[4:0] == 5'd0) ? 32 : 32'(op.width[4:0]);
		wmask = ALL32 >> (32 - w);
		ins_fld = op.ins & wmask;
		bmask = '0;

		if (op.mem) begin
			off = 32'(op.offset[2:0]);
			sh = 40 - off - w;
			m40 = {8'h00, wmask} << sh;
			last = (off + w - 1) >> 3;
			fld = 32'((op.src >> sh) & {8'h00, wmask});
			upd = op.src;
			for (int i = 0; i <= int'(last); i++)
				bmask[4 - i] = 1'b1;
			case (op.act)
				ACT_CHG: upd = op.src ^ m40;
				ACT_CLR: upd = op.src & ~m40;
				ACT_SET: upd = op.src | m40;
				ACT_INS: upd = (op.src & ~m40) | ({8'h00, ins_fld} << sh);
				default: bmask = '0;
			endcase
		end else begin
			// register field wraps around bit 0
			off = 32'(op.offset[4:0]);
			reg_val = op.src[31:0];
			m32 = spin_right(wmask << (32 - w), off);
			fld = spin_left(reg_val, off) >> (32 - w);
			case (op.act)
				ACT_CHG: reg_val = reg_val ^ m32;
				ACT_CLR: reg_val = reg_val & ~m32;
				ACT_SET: reg_val = reg_val | m32;
				ACT_INS: reg_val = (reg_val & ~m32) | spin_right(ins_fld << (32 - w), off);
				default: ;
			endcase
			upd = {8'h00, reg_val};
		end

		// insert flags come from the inserted value, the rest from the old field
		if (op.act == ACT_INS) begin
			n = ins_fld[w - 1];
			res.flag_z = (ins_fld == '0);
		end else begin
			n = fld[w - 1];
			res.flag_z = (fld == '0);
		end

		res.result_value = '0;
		case (op.act)
			ACT_EXTU: res.result_value = fld;
			ACT_EXTS: res.result_value = n ? (fld | ~wmask) : fld;
			ACT_FFO: begin
				// a zero field reports offset plus width
				pos = w;
				for (int i = 0; i < int'(w); i++) begin
					if (fld[w - 1 - i]) begin
						pos = i;
						break;
					end
				end
				res.result_value = op.offset + pos;
			end
			default: ;
		endcase

		res.updated_data = upd;
		res.byte_write_mask = bmask;
		res.flag_n = n;
		return res;
	endfunction

	function automatic bf_op_t make_op(input action_t act, input logic mem,
			input logic [31:0] offset, input logic [5:0] width,
			input logic [WIN_W-1:0] src, input logic [31:0] ins);
		bf_op_t op;
		op.act = act;
		op.mem = mem;
		op.offset = offset;
		op.width = width;
		op.src = src;
		op.ins = ins;
		return op;
	endfunction

	// random instruction, biased toward sparse and dense operands
	function automatic bf_op_t random_op(input logic mem);
		bf_op_t      op;
		logic [63:0] r64;

		op.act = action_t'($urandom_range(7));
		op.mem = mem;
		case ($urandom_range(3))
			0: op.offset = $urandom;
			1: op.offset = $urandom_range(63);
			2: op.offset = 32'(-int'($urandom_range(64, 1)));
			default: op.offset = $urandom_range(31);
		endcase
		// mostly legal widths, a few that rely on the five-bit fold
		if ($urandom_range(19) == 0)
			op.width = 6'($urandom_range(63));
		else
			op.width = 6'($urandom_range(32, 1));
		r64 = {$urandom, $urandom};
		case ($urandom_range(7))
			0: op.src = '0;
			1: op.src = 40'd1 << $urandom_range(WIN_W - 1);
			2: op.src = '1;
			default: op.src = r64[WIN_W-1:0];
		endcase
		op.ins = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom);
		return op;
	endfunction

	// drive one beat at the falling edge and record its expectation on acceptance
	task automatic send_item(input bf_op_t op);
		while (idle_en && $urandom_range(99) < 36) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op.mem;
		s_tdata  <= {7'd0, op.ins, op.src, op.width, op.offset, op.act};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		expected_q.push_back(predict_bitfield(op));
		@(negedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
		mismatches++;
	endtask

	// check each result beat against the oldest expectation
	always @(posedge clk) begin
		out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %h",
					$time, m_tdata);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (m_tdata[39:0] !== want.updated_data)
					report_mismatch("updated_data", 64'(want.updated_data),
						64'(m_tdata[39:0]));
				if (m_tdata[44:40] !== want.byte_write_mask)
					report_mismatch("byte_write_mask", 64'(want.byte_write_mask),
						64'(m_tdata[44:40]));
				if (m_tdata[76:45] !== want.result_value)
					report_mismatch("result_value", 64'(want.result_value),
						64'(m_tdata[76:45]));
				if (m_tdata[77] !== want.flag_n)
					report_mismatch("flag_n", 64'(want.flag_n), 64'(m_tdata[77]));
				if (m_tdata[78] !== want.flag_z)
					report_mismatch("flag_z", 64'(want.flag_z), 64'(m_tdata[78]));
			end
		end
	end

	// field extremes, every action in both modes, wrap and fold corner cases
	task automatic test_directed();
		send_item(make_op(ACT_TST,  1'b0, 32'd0,          6'd32, 40'h0,            32'h0));
		send_item(make_op(ACT_EXTU, 1'b0, 32'd31,         6'd32, 40'h00_8000_0001, 32'h0));
		send_item(make_op(ACT_EXTS, 1'b0, 32'hffff_ffff,  6'd4,  40'h00_f000_000f, 32'h0));
		send_item(make_op(ACT_EXTS, 1'b1, 32'd7,          6'd32, 40'hff_ffff_ffff, 32'h0));
		send_item(make_op(ACT_EXTU, 1'b1, 32'd0,          6'd1,  40'h80_0000_0000, 32'h0));
		// find-first-one on an all-zero field
		send_item(make_op(ACT_FFO,  1'b0, 32'd100,        6'd8,  40'h0,            32'h0));
		// find-first-one with large offsets, where the offset sum can wrap
		send_item(make_op(ACT_FFO,  1'b0, 32'h7fff_fffc,  6'd16, 40'h00_0000_0001, 32'h0));
		send_item(make_op(ACT_FFO,  1'b1, 32'hffff_fff8,  6'd32, 40'h00_0000_0001, 32'h0));
		send_item(make_op(ACT_FFO,  1'b1, 32'd3,          6'd5,  40'h0,            32'h0));
		send_item(make_op(ACT_FFO,  1'b0, 32'hffff_fffe,  6'd32, 40'h0,            32'h0));
		send_item(make_op(ACT_CHG,  1'b0, 32'd5,          6'd20, 40'h12_3456_789a, 32'h0));
		send_item(make_op(ACT_CLR,  1'b0, 32'd28,         6'd8,  40'hff_ffff_ffff, 32'h0));
		send_item(make_op(ACT_SET,  1'b0, 32'd30,         6'd4,  40'h0,            32'h0));
		// insert flags follow the inserted value
		send_item(make_op(ACT_INS,  1'b0, 32'hffff_fffd,  6'd12, 40'h0,            32'hffff_f800));
		send_item(make_op(ACT_INS,  1'b0, 32'd17,         6'd32, 40'hff_ffff_ffff, 32'h0));
		send_item(make_op(ACT_CHG,  1'b1, 32'd7,          6'd32, 40'h5a_a55a_a55a, 32'h0));
		send_item(make_op(ACT_CLR,  1'b1, 32'd2,          6'd6,  40'hff_ffff_ffff, 32'h0));
		send_item(make_op(ACT_SET,  1'b1, 32'd5,          6'd11, 40'h0,            32'h0));
		send_item(make_op(ACT_INS,  1'b1, 32'd4,          6'd9,  40'h0,            32'h0000_0100));
		send_item(make_op(ACT_INS,  1'b1, 32'h8000_0001,  6'd1,  40'hff_ffff_ffff, 32'h0));
		send_item(make_op(ACT_TST,  1'b1, 32'd6,          6'd3,  40'h0f_1e2d_3c4b, 32'h0));
		// widths outside 1..32 fold onto their low five bits
		send_item(make_op(ACT_EXTU, 1'b0, 32'd9,          6'd0,  40'hc3_dead_beef, 32'h0));
		send_item(make_op(ACT_EXTS, 1'b1, 32'd1,          6'd33, 40'h40_0000_0000, 32'h0));
		send_item(make_op(ACT_INS,  1'b0, 32'd3,          6'd63, 40'h0,            32'hffff_ffff));
		send_item(make_op(ACT_EXTU, 1'b0, 32'h8000_0000,  6'd1,  40'hff_ffff_ffff, 32'h0));
	endtask

	task automatic test_register_ops(input int count);
		repeat (count) send_item(random_op(1'b0));
	endtask

	task automatic test_memory_ops(input int count);
		repeat (count) send_item(random_op(1'b1));
	endtask

	// full-rate stretch: no gaps on input, no stalls on output
	task automatic test_back_to_back(input int count);
		idle_en = 1'b0;
		repeat (count) send_item(random_op(1'($urandom_range(1))));
		idle_en = 1'b1;
	endtask

	task automatic test_mixed(input int count);
		repeat (count) send_item(random_op(1'($urandom_range(1))));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_register_ops(300);
		test_memory_ops(300);
		test_back_to_back(300);
		test_mixed(325);

		// hold the input idle and let the pipeline drain
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);

		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/bfu_pkg.sv
hw/rtl/bfu_decode.sv
hw/rtl/bfu_align.sv
hw/rtl/bfu_finish.sv
hw/rtl/bitfield_instruction_unit.sv
test/bitfield_instruction_unit_test.sv
